FILE: src/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
`default_nettype none
package tli_pkg;

  // Item kinds on the input tuser.
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_FORWARD = 2'd1;
  localparam logic [1:0] KIND_INVERSE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Register index of the point count.
  localparam logic REG_NUM_POINTS = 1'b0;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned PROD_W = 66;

  // Request to the shared multiply and divide unit.
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a_mag;
    logic [MAG_W-1:0] b_mag;
    logic [MAG_W-1:0] d_mag;
  } md_req_t;

  // Response of the shared multiply and divide unit.
  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } md_rsp_t;

endpackage
`default_nettype wire

FILE: src/tli_mem.sv
// Point memory: one write port and one registered read port of (x,y) words.
`default_nettype none
module tli_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/tli_muldiv.sv
// Shared shift-add multiplier and restoring divider over one 66-bit adder.
`default_nettype none
module tli_muldiv (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tli_pkg::md_req_t req,
  output tli_pkg::md_rsp_t     rsp
);
  import tli_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_DIV  = 3'b100
  } mstate_t;

  mstate_t           ph;
  logic [6:0]        cnt;
  logic [PROD_W-1:0] acc;
  logic [MAG_W-1:0]  mb;
  logic [MAG_W-1:0]  a_r;
  logic [MAG_W-1:0]  d_r;
  logic [MAG_W-1:0]  rem;
  logic              done;
  logic [MAG_W:0]    rem_sh;
  logic [PROD_W-1:0] opa;
  logic [PROD_W-1:0] opb;
  logic              cin;
  logic [PROD_W-1:0] sum;

  // Operand selection for the one adder: accumulate or trial subtract.
  always_comb begin
    rem_sh = {rem, acc[PROD_W-1]};
    opa    = '0;
    opb    = '0;
    cin    = 1'b0;
    unique case (ph)
      M_MUL: begin
        opa = {acc[PROD_W-2:0], 1'b0};
        opb = mb[MAG_W-1] ? PROD_W'(a_r) : '0;
      end
      M_DIV: begin
        opa = PROD_W'(rem_sh);
        opb = ~PROD_W'(d_r);
        cin = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
    sum = opa + opb + PROD_W'(cin);
  end

  // Sequencer: 33 multiply steps, then 66 quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= M_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      unique case (ph)
        M_IDLE: begin
          if (req.start) begin
            acc <= '0;
            mb  <= req.b_mag;
            a_r <= req.a_mag;
            d_r <= req.d_mag;
            cnt <= 7'(MAG_W);
            ph  <= M_MUL;
          end
        end
        M_MUL: begin
          acc <= sum;
          mb  <= {mb[MAG_W-2:0], 1'b0};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            cnt <= 7'(PROD_W);
            rem <= '0;
            ph  <= M_DIV;
          end
        end
        M_DIV: begin
          if (!sum[PROD_W-1]) begin
            rem <= sum[MAG_W-1:0];
          end else begin
            rem <= rem_sh[MAG_W-1:0];
          end
          acc <= {acc[PROD_W-2:0], ~sum[PROD_W-1]};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            done <= 1'b1;
            ph   <= M_IDLE;
          end
        end
        default: begin
          ph <= M_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = acc;

endmodule
`default_nettype wire

FILE: src/table_linear_interpolator.sv
// Top level of the table linear interpolator: sequencer, config and output beat.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tdata point fields and query, tuser kind
// m_       out  m_tvalid/m_tready    tdata value, tuser status
// apb      in   psel/penable/pready  num_points at address 0
//
// A forward query runs a binary search over the point memory and then the shared
// multiply/divide unit; an inverse query scans the points and uses the same unit
// when an interval brackets it. The memory's single read port sets the search and
// scan pace. Reset is synchronous; the table is not cleared. A result waits in
// the output register while the next item is already accepted.
`default_nettype none
module table_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input beat.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [103:0] s_tdata, // point_index[5:0], point_x, point_y, query, zero pad
  input  wire logic [1:0]   s_tuser, // kind
  // Output beat.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [31:0]  m_tdata, // value
  output logic      [1:0]   m_tuser, // status
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import tli_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 2);
  localparam int unsigned LW = CW + 1;
  localparam int unsigned EW = (CW > 7) ? CW : 7;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_ONE_RD   = 12'b000000000010,
    S_ONE_GET  = 12'b000000000100,
    S_FS_RD    = 12'b000000001000,
    S_FS_CMP   = 12'b000000010000,
    S_F_RDLO   = 12'b000000100000,
    S_F_RDUP   = 12'b000001000000,
    S_F_GETUP  = 12'b000010000000,
    S_INV_RD   = 12'b000100000000,
    S_INV_SCAN = 12'b001000000000,
    S_MD       = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t               state;
  logic [6:0]           num_points;
  logic [EW-1:0]        np_ext;
  logic [EW-1:0]        n_ext;
  logic [CW-1:0]        n;
  logic [CW-1:0]        n_r;
  logic [1:0]           kind_r;
  logic signed [31:0]   q_r;
  logic [CW-1:0]        above;
  logic [CW-1:0]        below;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        cnt;
  logic [AW-1:0]        lo;
  logic [AW-1:0]        raddr;
  logic [63:0]          rdata;
  logic signed [31:0]   rd_x;
  logic signed [31:0]   rd_y;
  logic signed [31:0]   x_lo;
  logic signed [31:0]   y_lo;
  logic signed [31:0]   prev_x;
  logic signed [31:0]   prev_y;
  logic signed [31:0]   best_x;
  logic [MAG_W-1:0]     best_d;
  logic signed [31:0]   base;
  logic                 neg;
  logic [31:0]          res_value;
  logic [1:0]           res_status;
  md_req_t              md_req;
  md_rsp_t              md_rsp;
  logic                 s_acc;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        above_nx;
  logic [CW-1:0]        below_nx;
  logic signed [CW:0]   lo_raw;
  logic signed [CW:0]   lo_cl;
  logic signed [CW:0]   n_s;
  logic signed [MAG_W-1:0] cur_d_s;
  logic [MAG_W-1:0]     cur_d;
  logic                 bracket;
  logic signed [35:0]   sum36;

  function automatic logic [MAG_W-1:0] abs33(input logic signed [MAG_W-1:0] v);
    abs33 = v[MAG_W-1] ? MAG_W'(-v) : v;
  endfunction

  function automatic logic signed [MAG_W-1:0] diff33(input logic signed [31:0] p,
                                                     input logic signed [31:0] m);
    diff33 = MAG_W'(p) - MAG_W'(m);
  endfunction

  // Effective point count, clamped to the memory depth.
  always_comb begin
    np_ext = EW'(num_points);
    n_ext  = (np_ext > EW'(MAX_POINTS)) ? EW'(MAX_POINTS) : np_ext;
    n      = n_ext[CW-1:0];
  end

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_NUM_POINTS) begin
      num_points <= pwdata[6:0];
    end
  end
  assign prdata = (paddr[2] == REG_NUM_POINTS) ? {25'd0, num_points} : 32'd0;

  // Input acceptance and table writes.
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign mem_we    = s_acc && s_tuser == KIND_WRITE && 32'(s_tdata[5:0]) < MAX_POINTS;
  assign mem_waddr = AW'(s_tdata[5:0]);

  tli_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({s_tdata[69:38], s_tdata[37:6]}),
    .raddr (raddr),
    .rdata (rdata)
  );

  tli_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign rd_x = rdata[31:0];
  assign rd_y = rdata[63:32];

  // Search step: midpoint, next bounds and the clamped lower index.
  always_comb begin
    mid_sum  = {1'b0, above} + {1'b0, below};
    mid      = mid_sum[CW:1];
    above_nx = above;
    below_nx = below;
    if (q_r < rd_x) begin
      above_nx = mid;
    end else begin
      below_nx = mid;
    end
    if (q_r == rd_x) begin
      lo_raw = LW'($signed({1'b0, mid}) - 1);
    end else begin
      lo_raw = LW'($signed({1'b0, below_nx}) - 1);
    end
    n_s   = $signed({1'b0, n_r});
    lo_cl = lo_raw;
    if (lo_raw >= n_s - 1) begin
      lo_cl = LW'(n_s - 2);
    end
    if (lo_cl < 0) begin
      lo_cl = '0;
    end
  end

  // Scan step: distance to the current y and the strict bracket test.
  always_comb begin
    cur_d_s = diff33(q_r, rd_y);
    cur_d   = abs33(cur_d_s);
    bracket = (q_r < prev_y && q_r > rd_y) || (q_r > prev_y && q_r < rd_y);
  end

  // Read address of the point memory.
  always_comb begin
    unique case (state)
      S_FS_RD:    raddr = AW'(mid - 1'b1);
      S_F_RDLO:   raddr = lo;
      S_F_RDUP:   raddr = lo + 1'b1;
      S_INV_SCAN: raddr = cnt[AW-1:0];
      default:    raddr = '0;
    endcase
  end

  // Final sum of base and signed quotient; the sequencer saturates it.
  always_comb begin
    if (neg) begin
      sum36 = 36'(base) - $signed({1'b0, md_rsp.quot[34:0]});
    end else begin
      sum36 = 36'(base) + $signed({1'b0, md_rsp.quot[34:0]});
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      md_req.start <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      md_req.start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            kind_r     <= s_tuser;
            q_r        <= s_tdata[101:70];
            n_r        <= n;
            res_value  <= '0;
            res_status <= ST_OK;
            above      <= n + 1'b1;
            below      <= '0;
            cnt        <= '0;
            if (s_tuser != KIND_FORWARD && s_tuser != KIND_INVERSE) begin
              state <= S_DONE;
            end else if (n == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else if (n == CW'(1)) begin
              state <= S_ONE_RD;
            end else if (s_tuser == KIND_FORWARD) begin
              state <= S_FS_RD;
            end else begin
              state <= S_INV_RD;
            end
          end
        end
        S_ONE_RD: begin
          state <= S_ONE_GET;
        end
        S_ONE_GET: begin
          res_value <= (kind_r == KIND_FORWARD) ? rd_y : rd_x;
          state     <= S_DONE;
        end
        S_FS_RD: begin
          state <= S_FS_CMP;
        end
        S_FS_CMP: begin
          above <= above_nx;
          below <= below_nx;
          lo    <= AW'(lo_cl);
          if (q_r == rd_x || above_nx - below_nx <= CW'(1)) begin
            state <= S_F_RDLO;
          end else begin
            state <= S_FS_RD;
          end
        end
        S_F_RDLO: begin
          state <= S_F_RDUP;
        end
        S_F_RDUP: begin
          x_lo  <= rd_x;
          y_lo  <= rd_y;
          state <= S_F_GETUP;
        end
        S_F_GETUP: begin
          if (rd_x == x_lo) begin
            res_value <= y_lo;
            state     <= S_DONE;
          end else begin
            md_req.start <= 1'b1;
            md_req.a_mag <= abs33(diff33(rd_y, y_lo));
            md_req.b_mag <= abs33(diff33(q_r, x_lo));
            md_req.d_mag <= abs33(diff33(rd_x, x_lo));
            neg   <= diff33(rd_y, y_lo) < 0 ^ diff33(q_r, x_lo) < 0 ^
                     diff33(rd_x, x_lo) < 0;
            base  <= y_lo;
            state <= S_MD;
          end
        end
        S_INV_RD: begin
          cnt   <= CW'(1);
          state <= S_INV_SCAN;
        end
        S_INV_SCAN: begin
          // Data here is entry cnt-1.
          cnt    <= cnt + 1'b1;
          prev_x <= rd_x;
          prev_y <= rd_y;
          if (cnt == CW'(1)) begin
            best_d <= cur_d;
            best_x <= rd_x;
            if (n_r == CW'(1)) begin
              res_value <= rd_x;
              state     <= S_DONE;
            end
          end else if (bracket) begin
            md_req.start <= 1'b1;
            md_req.a_mag <= abs33(diff33(rd_x, prev_x));
            md_req.b_mag <= abs33(diff33(q_r, prev_y));
            md_req.d_mag <= abs33(diff33(rd_y, prev_y));
            neg   <= diff33(rd_x, prev_x) < 0 ^ diff33(q_r, prev_y) < 0 ^
                     diff33(rd_y, prev_y) < 0;
            base  <= prev_x;
            state <= S_MD;
          end else begin
            if (cur_d < best_d) begin
              best_d <= cur_d;
              best_x <= rd_x;
            end
            if (cnt == n_r) begin
              res_value <= (cur_d < best_d) ? rd_x : best_x;
              state     <= S_DONE;
            end
          end
        end
        S_MD: begin
          if (md_rsp.done) begin
            if (md_rsp.quot > PROD_W'(66'd1 << 34)) begin
              res_status <= ST_SAT;
              res_value  <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (sum36 > 36'sd2147483647) begin
              res_status <= ST_SAT;
              res_value  <= 32'h7FFF_FFFF;
            end else if (sum36 < -36'sd2147483648) begin
              res_status <= ST_SAT;
              res_value  <= 32'h8000_0000;
            end else begin
              res_value <= sum36[31:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_value;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
